// File: hw/rtl/rpoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpoc_pkg;

	localparam int COORD_BITS  = 12;
	localparam int SPAN_BITS   = COORD_BITS + 1;
	localparam int CORNER_SIZE = 8;
	localparam int EDGE_WIDTH  = 2;
	localparam int TITLE_ROWS  = 4;

	localparam logic [7:0] ALPHA_FG = 8'd155;
	localparam logic [8:0] ALPHA_BG = 9'd256 - 9'(ALPHA_FG);

	localparam logic [23:0] COLOR_BODY  = 24'h04080F;
	localparam logic [23:0] COLOR_TITLE = 24'h070F1C;
	localparam logic [23:0] COLOR_EDGE  = 24'h33CCFF;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [SPAN_BITS-1:0]  span_t;
	typedef logic [23:0]           rgb_t;
	typedef logic [4:0]            shift_t;

	// geometry of one pixel relative to the panel
	typedef struct packed {
		logic   in_panel;
		logic   title;
		coord_t nx;
		coord_t ny;
	} geom_t;

	// (bg*(256-a) + fg*a) >> 8, truncated
	function automatic logic [7:0] blend_channel(input logic [7:0] bg, input logic [7:0] fg);
		logic [16:0] acc;
		acc = 17'(bg * ALPHA_BG) + 17'(fg * ALPHA_FG);
		return acc[15:8];
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rpoc_geom.sv
`timescale 1ns / 1ps
`default_nettype none
module rpoc_geom (
	input  wire logic            clk,
	input  wire logic            en_s1,
	input  wire logic            en_s2,
	input  wire rpoc_pkg::coord_t pixel_x,
	input  wire rpoc_pkg::coord_t pixel_y,
	input  wire rpoc_pkg::coord_t panel_left,
	input  wire rpoc_pkg::coord_t panel_top,
	input  wire rpoc_pkg::span_t  panel_width,
	input  wire rpoc_pkg::span_t  panel_height,
	output rpoc_pkg::geom_t       geom_s2
);
	import rpoc_pkg::*;

	coord_t dx;
	coord_t dy;
	logic   in_rect;
	logic   inside_s1;
	coord_t dx_s1;
	coord_t dy_s1;
	span_t  rx;
	span_t  ry;

	// stage 1: offsets and rectangle test, no wrap
	always_comb begin
		dx = pixel_x - panel_left;
		dy = pixel_y - panel_top;
		in_rect = (pixel_x >= panel_left) && (pixel_y >= panel_top) &&
			({1'b0, dx} < panel_width) && ({1'b0, dy} < panel_height);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			inside_s1 <= in_rect;
			dx_s1     <= dx;
			dy_s1     <= dy;
		end
	end

	// stage 2: distance to the nearest edge on each axis
	always_comb begin
		rx = panel_width - SPAN_BITS'(1) - {1'b0, dx_s1};
		ry = panel_height - SPAN_BITS'(1) - {1'b0, dy_s1};
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			geom_s2.in_panel <= inside_s1;
			geom_s2.title    <= (dy_s1 < COORD_BITS'(TITLE_ROWS));
			geom_s2.nx       <= ({1'b0, dx_s1} < rx) ? dx_s1 : rx[COORD_BITS-1:0];
			geom_s2.ny       <= ({1'b0, dy_s1} < ry) ? dy_s1 : ry[COORD_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rpoc_shade.sv
`timescale 1ns / 1ps
`default_nettype none
module rpoc_shade (
	input  wire logic            clk,
	input  wire logic            en_s3,
	input  wire rpoc_pkg::geom_t geom_s2,
	input  wire rpoc_pkg::rgb_t  wallpaper_s2,
	output rpoc_pkg::rgb_t       color_s3,
	output logic                 hit_s3
);
	import rpoc_pkg::*;

	rgb_t        fg;
	rgb_t        mixed;
	logic [SPAN_BITS-1:0] corner_sum;
	logic        drawn;
	logic        edge_px;

	always_comb begin
		fg = geom_s2.title ? COLOR_TITLE : COLOR_BODY;
		mixed = {blend_channel(wallpaper_s2[23:16], fg[23:16]),
			blend_channel(wallpaper_s2[15:8], fg[15:8]),
			blend_channel(wallpaper_s2[7:0], fg[7:0])};
		corner_sum = {1'b0, geom_s2.nx} + {1'b0, geom_s2.ny};
		// corner triangles stay transparent
		drawn = geom_s2.in_panel && (corner_sum >= SPAN_BITS'(CORNER_SIZE));
		edge_px = (geom_s2.nx < COORD_BITS'(EDGE_WIDTH)) ||
			(geom_s2.ny < COORD_BITS'(EDGE_WIDTH));
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			hit_s3 <= drawn;
			if (!drawn) begin
				color_s3 <= wallpaper_s2;
			end else if (edge_px) begin
				color_s3 <= COLOR_EDGE;
			end else begin
				color_s3 <= mixed;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rpoc_pack.sv
`timescale 1ns / 1ps
`default_nettype none
module rpoc_pack (
	input  wire logic             clk,
	input  wire logic             en_s4,
	input  wire logic             rgb565,
	input  wire rpoc_pkg::shift_t red_shift,
	input  wire rpoc_pkg::shift_t green_shift,
	input  wire rpoc_pkg::shift_t blue_shift,
	input  wire rpoc_pkg::rgb_t   color_s3,
	input  wire logic             hit_s3,
	output logic [31:0]           word_s4,
	output logic                  hit_s4
);
	import rpoc_pkg::*;

	logic [31:0] word;

	always_comb begin
		if (rgb565) begin
			word = {16'd0, color_s3[23:19], color_s3[15:10], color_s3[7:3]};
		end else begin
			// bytes shifted past bit 31 lose their top bits
			word = ({24'd0, color_s3[23:16]} << red_shift) |
				({24'd0, color_s3[15:8]} << green_shift) |
				({24'd0, color_s3[7:0]} << blue_shift);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			word_s4 <= word;
			hit_s4  <= hit_s3;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rounded_panel_overlay_compositor.sv
`timescale 1ns / 1ps
`default_nettype none
// Rounded panel overlay compositor: one screen pixel (x, y, RGB888 wallpaper)
// in, one packed framebuffer word out. Pixels outside the panel rectangle, or
// in its four cut corners (nearest-edge distances nx+ny below the corner
// size), pass the wallpaper through with panel_hit low. Inside, the outer
// two rows and columns take the border color, the rest is the wallpaper
// blended at 155/256 with the title color (first four rows) or body color.
// The word is RGB565 or a 32 bpp word with programmable byte offsets; bits
// no byte covers are zero. Throughput is one pixel per clock unless out_stall
// holds the pipe; there are four register stages (rectangle test, edge
// distances, blend/classify, pack). Each stage holds only when the stage
// after it is full and held, so bubbles are squeezed out and an input
// transfer is still taken while a result waits on out_stall if some stage
// is empty. Configuration registers are written through cfg_valid/cfg_ready
// (always ready) and must only change while no pixel is in flight.
module rounded_panel_overlay_compositor (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire rpoc_pkg::coord_t pixel_x,
	input  wire rpoc_pkg::coord_t pixel_y,
	input  wire rpoc_pkg::rgb_t   wallpaper_rgb,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [31:0]           fb_word,
	output logic                  panel_hit,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [31:0]      cfg_data
);
	import rpoc_pkg::*;

	typedef enum logic [2:0] {
		REG_PANEL_LEFT   = 3'd0,
		REG_PANEL_TOP    = 3'd1,
		REG_PANEL_WIDTH  = 3'd2,
		REG_PANEL_HEIGHT = 3'd3,
		REG_OUT_FORMAT   = 3'd4,
		REG_RED_SHIFT    = 3'd5,
		REG_GREEN_SHIFT  = 3'd6,
		REG_BLUE_SHIFT   = 3'd7
	} cfg_reg_t;

	// configuration
	coord_t panel_left_q;
	coord_t panel_top_q;
	span_t  panel_width_q;
	span_t  panel_height_q;
	logic   rgb565_q;
	shift_t red_shift_q;
	shift_t green_shift_q;
	shift_t blue_shift_q;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// wallpaper rides alongside the geometry
	rgb_t  wallpaper_s1;
	rgb_t  wallpaper_s2;
	geom_t geom_s2;
	rgb_t  color_s3;
	logic  hit_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_left_q   <= '0;
			panel_top_q    <= '0;
			panel_width_q  <= '0;
			panel_height_q <= '0;
			rgb565_q       <= 1'b0;
			red_shift_q    <= shift_t'(16);
			green_shift_q  <= shift_t'(8);
			blue_shift_q   <= shift_t'(0);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PANEL_LEFT:   panel_left_q   <= cfg_data[COORD_BITS-1:0];
				REG_PANEL_TOP:    panel_top_q    <= cfg_data[COORD_BITS-1:0];
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_data[SPAN_BITS-1:0];
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data[SPAN_BITS-1:0];
				REG_OUT_FORMAT:   rgb565_q       <= cfg_data[0];
				REG_RED_SHIFT:    red_shift_q    <= cfg_data[4:0];
				REG_GREEN_SHIFT:  green_shift_q  <= cfg_data[4:0];
				REG_BLUE_SHIFT:   blue_shift_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on
	assign en_s4 = !valid_s4 || !out_stall;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) wallpaper_s1 <= wallpaper_rgb;
		if (en_s2) wallpaper_s2 <= wallpaper_s1;
	end

	rpoc_geom u_geom (
		.clk          (clk),
		.en_s1        (en_s1),
		.en_s2        (en_s2),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.panel_left   (panel_left_q),
		.panel_top    (panel_top_q),
		.panel_width  (panel_width_q),
		.panel_height (panel_height_q),
		.geom_s2      (geom_s2)
	);

	rpoc_shade u_shade (
		.clk          (clk),
		.en_s3        (en_s3),
		.geom_s2      (geom_s2),
		.wallpaper_s2 (wallpaper_s2),
		.color_s3     (color_s3),
		.hit_s3       (hit_s3)
	);

	rpoc_pack u_pack (
		.clk         (clk),
		.en_s4       (en_s4),
		.rgb565      (rgb565_q),
		.red_shift   (red_shift_q),
		.green_shift (green_shift_q),
		.blue_shift  (blue_shift_q),
		.color_s3    (color_s3),
		.hit_s3      (hit_s3),
		.word_s4     (fb_word),
		.hit_s4      (panel_hit)
	);

endmodule
`default_nettype wire

// File: tb/rounded_panel_overlay_compositor_tb.sv
`timescale 1ns / 1ps
// Pixel stream testbench for the panel overlay compositor.
// Every pixel transfer on the input side is turned into an expected framebuffer
// word by a local model of the panel geometry, blend and pack logic. Each output
// transfer is compared against the oldest expected word.
module rounded_panel_overlay_compositor_tb;
	import rpoc_pkg::*;

	// register map of the config port
	localparam logic [2:0] REG_LEFT        = 3'd0;
	localparam logic [2:0] REG_TOP         = 3'd1;
	localparam logic [2:0] REG_WIDTH       = 3'd2;
	localparam logic [2:0] REG_HEIGHT      = 3'd3;
	localparam logic [2:0] REG_FORMAT      = 3'd4;
	localparam logic [2:0] REG_RED_SHIFT   = 3'd5;
	localparam logic [2:0] REG_GREEN_SHIFT = 3'd6;
	localparam logic [2:0] REG_BLUE_SHIFT  = 3'd7;

	localparam logic FMT_XRGB   = 1'b0;
	localparam logic FMT_RGB565 = 1'b1;

	// panel look, kept independent of the package constants
	localparam int          OVERLAY_ALPHA = 155;
	localparam int          CORNER_CUT    = 8;
	localparam int          BORDER_PX     = 2;
	localparam int          TITLE_LINES   = 4;
	localparam logic [23:0] BORDER_RGB    = 24'h33CCFF;
	localparam logic [23:0] TITLE_RGB     = 24'h070F1C;
	localparam logic [23:0] BODY_RGB      = 24'h04080F;

	localparam int MAX_CYCLES = 200000;
	localparam int DRAIN_WAIT = 16;

	typedef struct packed {
		logic [31:0] word;
		logic        hit;
	} pixel_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	coord_t      pixel_x;
	coord_t      pixel_y;
	rgb_t        wallpaper_rgb;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] fb_word;
	logic        panel_hit;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	rounded_panel_overlay_compositor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.wallpaper_rgb (wallpaper_rgb),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fb_word       (fb_word),
		.panel_hit     (panel_hit),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// shadow copy of the config registers, reset values
	coord_t panel_left_q   = '0;
	coord_t panel_top_q    = '0;
	span_t  panel_width_q  = '0;
	span_t  panel_height_q = '0;
	logic   out_format_q   = FMT_XRGB;
	shift_t red_shift_q    = 5'd16;
	shift_t green_shift_q  = 5'd8;
	shift_t blue_shift_q   = 5'd0;

	pixel_result_t expected_pixels[$];
	pixel_result_t oldest_pixel;
	int            mismatch_count = 0;
	int            cycle_count    = 0;

	// sender burst shaping
	int burst_left = 0;
	int gap_max    = 0;
	int burst_max  = 1;

	// receiver stall pattern; hold_len forces one long unbroken stall
	int rx_pct     = 0;
	int rx_run_max = 1;
	int run_left   = 0;
	logic run_stall = 1'b0;
	int hold_len   = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Local model of one pixel
	// ------------------------------------------------------------------

	// one channel of the overlay blend, truncated
	function automatic logic [7:0] mix8(input logic [7:0] bg, input logic [7:0] fg);
		int acc;
		acc = int'(bg) * (256 - OVERLAY_ALPHA) + int'(fg) * OVERLAY_ALPHA;
		return acc[15:8];
	endfunction

	function automatic pixel_result_t compose_pixel(input coord_t x, input coord_t y,
			input rgb_t wp);
		int            dx, dy, nx, ny;
		rgb_t          color, tint;
		logic [63:0]   wide;
		pixel_result_t res;
		color   = wp;
		res.hit = 1'b0;
		dx = int'(x) - int'(panel_left_q);
		dy = int'(y) - int'(panel_top_q);
		// rectangle test is unwrapped, so a panel past 4095 is simply clipped
		if (dx >= 0 && dy >= 0 && dx < int'(panel_width_q) && dy < int'(panel_height_q)) begin
			// distance to the nearest vertical / horizontal panel edge
			nx = (dx < int'(panel_width_q) - 1 - dx) ? dx : int'(panel_width_q) - 1 - dx;
			ny = (dy < int'(panel_height_q) - 1 - dy) ? dy : int'(panel_height_q) - 1 - dy;
			// corner triangles show wallpaper and beat the border
			if (nx + ny >= CORNER_CUT) begin
				res.hit = 1'b1;
				if (nx < BORDER_PX || ny < BORDER_PX) begin
					color = BORDER_RGB;
				end else begin
					tint  = (dy < TITLE_LINES) ? TITLE_RGB : BODY_RGB;
					color = {mix8(wp[23:16], tint[23:16]), mix8(wp[15:8], tint[15:8]),
						mix8(wp[7:0], tint[7:0])};
				end
			end
		end
		if (out_format_q == FMT_RGB565) begin
			res.word = {16'h0000, color[23:19], color[15:10], color[7:3]};
		end else begin
			// bytes shifted past bit 31 lose their top bits; overlaps are ORed
			wide = (64'(color[23:16]) << red_shift_q) | (64'(color[15:8]) << green_shift_q)
				| (64'(color[7:0]) << blue_shift_q);
			res.word = wide[31:0];
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: expectations are queued at each input transfer and
	// retired in order at each output transfer. Inputs are driven at the
	// falling edge, so everything read here is settled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("output transfer with nothing expected: fb_word %h panel_hit %b",
					fb_word, panel_hit);
				mismatch_count++;
			end else begin
				oldest_pixel = expected_pixels.pop_front();
				if (fb_word !== oldest_pixel.word) begin
					$error("fb_word: expected %h, actual %h", oldest_pixel.word, fb_word);
					mismatch_count++;
				end
				if (panel_hit !== oldest_pixel.hit) begin
					$error("panel_hit: expected %b, actual %b", oldest_pixel.hit, panel_hit);
					mismatch_count++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			expected_pixels.push_back(compose_pixel(pixel_x, pixel_y, wallpaper_rgb));
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stall runs, or one long counted hold when asked.
	always @(negedge clk) begin
		if (hold_len > 0) begin
			hold_len--;
			out_stall <= 1'b1;
		end else begin
			if (run_left <= 0) begin
				run_stall = ($urandom_range(0, 99) < rx_pct);
				run_left  = $urandom_range(1, rx_run_max);
			end
			run_left--;
			out_stall <= run_stall;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// One pixel transfer. Valid stays high between pixels of a burst and
	// drops only for the gap in front of a new burst.
	task automatic send_pixel(input coord_t x, input coord_t y, input rgb_t wp);
		int gap;
		if (burst_left <= 0) begin
			gap        = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, burst_max);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid      <= 1'b1;
		pixel_x       <= x;
		pixel_y       <= y;
		wallpaper_rgb <= wp;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait until every expected word came back
	task automatic wait_drained();
		@(negedge clk);
		in_valid  <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LEFT:        panel_left_q   = value[11:0];
			REG_TOP:         panel_top_q    = value[11:0];
			REG_WIDTH:       panel_width_q  = value[12:0];
			REG_HEIGHT:      panel_height_q = value[12:0];
			REG_FORMAT:      out_format_q   = value[0];
			REG_RED_SHIFT:   red_shift_q    = value[4:0];
			REG_GREEN_SHIFT: green_shift_q  = value[4:0];
			REG_BLUE_SHIFT:  blue_shift_q   = value[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_panel(input int l, input int t, input int w, input int h);
		write_reg(REG_LEFT, l);
		write_reg(REG_TOP, t);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic set_format(input logic fmt, input int rs, input int gs, input int bs);
		write_reg(REG_FORMAT, 32'(fmt));
		write_reg(REG_RED_SHIFT, rs);
		write_reg(REG_GREEN_SHIFT, gs);
		write_reg(REG_BLUE_SHIFT, bs);
	endtask

	task automatic set_traffic(input int gaps, input int bursts, input int pct, input int runs);
		gap_max    = gaps;
		burst_max  = bursts;
		rx_pct     = pct;
		rx_run_max = runs;
	endtask

	function automatic int pick_shift();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 24;
			default: return $urandom_range(0, 24);
		endcase
	endfunction

	// mostly around the panel so edges, corners and title rows get hit
	function automatic coord_t near_coord(input int base, input int span);
		int lo, hi;
		if ($urandom_range(0, 4) == 0)
			return coord_t'($urandom_range(0, 4095));
		lo = base - 3;
		hi = base + span + 2;
		if (lo < 0)
			lo = 0;
		if (hi > 4095)
			hi = 4095;
		return coord_t'($urandom_range(hi, lo));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// out of reset the panel is disabled and the word is plain xRGB
	task automatic test_reset_state();
		set_traffic(0, 1000, 0, 1);
		send_pixel(12'd0, 12'd0, 24'h000000);
		send_pixel(12'd4095, 12'd4095, 24'hFFFFFF);
		send_pixel(12'd2048, 12'd1, 24'h5A3CC3);
	endtask

	// panel at (100,50), 40x30: walk across each region of the shape
	task automatic test_panel_regions();
		wait_drained();
		set_panel(100, 50, 40, 30);
		set_traffic(2, 4, 20, 3);
		send_pixel(12'd99, 12'd60, 24'hFFFFFF);   // left of panel
		send_pixel(12'd140, 12'd60, 24'h000000);  // one past right edge
		send_pixel(12'd110, 12'd49, 24'h123456);  // above
		send_pixel(12'd110, 12'd80, 24'hFFFFFF);  // one past bottom
		send_pixel(12'd100, 12'd50, 24'hFFFFFF);  // top-left cut corner
		send_pixel(12'd104, 12'd53, 24'hFFFFFF);  // last pixel of the corner cut
		send_pixel(12'd108, 12'd50, 24'h000000);  // top border
		send_pixel(12'd101, 12'd57, 24'hFFFFFF);  // left border, inner column
		send_pixel(12'd106, 12'd52, 24'hFFFFFF);  // title bar, first blended row
		send_pixel(12'd110, 12'd53, 24'h000000);  // last title row
		send_pixel(12'd110, 12'd54, 24'hFFFFFF);  // first body row
		send_pixel(12'd139, 12'd79, 24'h000000);  // bottom-right cut corner
		send_pixel(12'd135, 12'd75, 24'hA5A5A5);  // body near bottom-right
		send_pixel(12'd120, 12'd78, 24'hFFFFFF);  // bottom border
	endtask

	// RGB565 packing, then shifts at the top of the word with overlap
	task automatic test_packing();
		wait_drained();
		set_format(FMT_RGB565, 16, 8, 0);
		send_pixel(12'd106, 12'd52, 24'hFFFFFF);
		send_pixel(12'd99, 12'd60, 24'hFFFFFF);
		wait_drained();
		set_format(FMT_XRGB, 24, 20, 24);
		send_pixel(12'd99, 12'd60, 24'hFFFFFF);
		send_pixel(12'd120, 12'd78, 24'h000000);
	endtask

	task automatic test_degenerate_panels();
		wait_drained();
		set_format(FMT_XRGB, 16, 8, 0);
		// zero width, then zero height: nothing is inside
		set_panel(0, 0, 0, 4096);
		send_pixel(12'd5, 12'd5, 24'hFFFFFF);
		wait_drained();
		set_panel(0, 0, 4096, 0);
		send_pixel(12'd5, 12'd5, 24'hFFFFFF);
		wait_drained();
		// panel running off the end of the coordinate range
		set_panel(4090, 4000, 4096, 4096);
		send_pixel(12'd4095, 12'd4095, 24'hFFFFFF);
		send_pixel(12'd4089, 12'd4095, 24'hFFFFFF);
		wait_drained();
		// full screen
		set_panel(0, 0, 4096, 4096);
		send_pixel(12'd0, 12'd0, 24'h00FF00);
		send_pixel(12'd9, 12'd0, 24'h00FF00);
		wait_drained();
		// 5x5: every pixel sits in a corner cut
		set_panel(10, 10, 5, 5);
		send_pixel(12'd12, 12'd12, 24'hFFFFFF);
		wait_drained();
		// 20x6: only a thin title strip survives the corners and border
		set_panel(10, 10, 20, 6);
		send_pixel(12'd19, 12'd12, 24'hFFFFFF);
		send_pixel(12'd11, 12'd13, 24'hFFFFFF);
	endtask

	// random config per phase, random pixels aimed at the panel
	task automatic test_random_sweep(input int phases, input int per_phase);
		int l, t, w, h;
		for (int ph = 0; ph < phases; ph++) begin
			wait_drained();
			case ($urandom_range(0, 5))
				0:       l = 0;
				1:       l = 4095;
				default: l = $urandom_range(0, 4095);
			endcase
			case ($urandom_range(0, 5))
				0:       t = 0;
				1:       t = 4095;
				default: t = $urandom_range(0, 4095);
			endcase
			case ($urandom_range(0, 7))
				0:       w = 0;
				1:       w = 4096;
				2:       w = $urandom_range(1, 8);
				default: w = $urandom_range(9, 80);
			endcase
			case ($urandom_range(0, 7))
				0:       h = 0;
				1:       h = 4096;
				2:       h = $urandom_range(1, 8);
				default: h = $urandom_range(9, 80);
			endcase
			set_panel(l, t, w, h);
			set_format(1'($urandom_range(0, 1)), pick_shift(), pick_shift(), pick_shift());
			// every fourth phase runs flat out on both sides
			if (ph % 4 == 0)
				set_traffic(0, 1000, 0, 1);
			else
				set_traffic($urandom_range(1, 8), $urandom_range(1, 20),
					$urandom_range(10, 60), $urandom_range(1, 12));
			for (int i = 0; i < per_phase; i++)
				send_pixel(near_coord(l, w), near_coord(t, h), rgb_t'($urandom()));
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps pushing:
	// the pipeline fills and in_stall must hold the input side.
	task automatic test_backpressure(input int items);
		wait_drained();
		set_panel(200, 300, 48, 24);
		set_format(FMT_RGB565, 16, 8, 0);
		set_traffic(0, 1000, 0, 1);
		hold_len = 400;
		for (int i = 0; i < items; i++)
			send_pixel(near_coord(200, 48), near_coord(300, 24), rgb_t'($urandom()));
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		pixel_x       = '0;
		pixel_y       = '0;
		wallpaper_rgb = '0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_LEFT;
		cfg_data      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_panel_regions();
		test_packing();
		test_degenerate_panels();
		test_random_sweep(12, 100);
		test_backpressure(150);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rpoc_pkg.sv
hw/rtl/rpoc_geom.sv
hw/rtl/rpoc_shade.sv
hw/rtl/rpoc_pack.sv
hw/rtl/rounded_panel_overlay_compositor.sv
tb/rounded_panel_overlay_compositor_tb.sv
